// ----- rtl/ordered_list_insert_delete_assert.svh -----
// Assertion macros shared by the checker of the ordered list block.
`ifndef ORDERED_LIST_INSERT_DELETE_ASSERT_SVH
`define ORDERED_LIST_INSERT_DELETE_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define OLI_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Implication whose consequent is checked in the following clock cycle.
`define OLI_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- rtl/oli_pkg.sv -----
// Types and constants shared by the ordered list block.
`timescale 1ns / 1ps
`default_nettype none

package oli_pkg;

  localparam int DATA_W = 32;
  localparam int IDX_W  = 6;
  localparam int CMD_W  = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_FRONT  = 2'd0,
    CMD_BACK   = 2'd1,
    CMD_DELETE = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_LEFT,
    CELL_FROM_RIGHT,
    CELL_FROM_HEAD
  } cell_op_e;

  typedef struct packed {
    cell_op_e          op;
    logic [DATA_W-1:0] load_val;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/oli_cell.sv -----
// One storage cell of the list chain, holding a single entry.
`timescale 1ns / 1ps
`default_nettype none

module oli_cell (
  input  wire logic                           clk_i,
  input  wire oli_pkg::cell_ctrl_t            ctrl_i,
  input  wire logic [oli_pkg::DATA_W-1:0]     left_i,
  input  wire logic [oli_pkg::DATA_W-1:0]     right_i,
  input  wire logic [oli_pkg::DATA_W-1:0]     head_i,
  output logic      [oli_pkg::DATA_W-1:0]     data_o
);

  logic [oli_pkg::DATA_W-1:0] data_q;
  logic [oli_pkg::DATA_W-1:0] data_d;

  always_comb begin
    case (ctrl_i.op)
      oli_pkg::CELL_LOAD:       data_d = ctrl_i.load_val;
      oli_pkg::CELL_FROM_LEFT:  data_d = left_i;
      oli_pkg::CELL_FROM_RIGHT: data_d = right_i;
      oli_pkg::CELL_FROM_HEAD:  data_d = head_i;
      default:                  data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

// ----- rtl/ordered_list_insert_delete.sv -----
// Ordered list with front and back insert and delete at index, built as a chain of cells.
// A command updates the cells in its transfer cycle; its results are registered in the dump state.
// New commands stall until the dump of the N entries of the list ends (one result if empty).
// The dump moves the chain one entry per cycle unless the output stalls; list length sets its span.
// Reset clears the entry count and the control state; entry contents are not reset.
`timescale 1ns / 1ps
`default_nettype none

module ordered_list_insert_delete #(
  parameter int CAPACITY = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [oli_pkg::CMD_W-1:0]        cmd_i,
  input  wire logic signed [oli_pkg::DATA_W-1:0] value_i,
  input  wire logic [oli_pkg::IDX_W-1:0]        index_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic signed [oli_pkg::DATA_W-1:0]     entry_value_o,
  output logic      [oli_pkg::IDX_W-1:0]        position_o,
  output logic                                  last_o,
  output logic                                  empty_res_o,
  output logic                                  dropped_o
);

  localparam int CntW  = $clog2(CAPACITY + 1);
  localparam int IdxW  = oli_pkg::IDX_W;
  localparam int CmpW  = ((CntW > IdxW) ? CntW : IdxW) + 1;
  localparam int DataW = oli_pkg::DATA_W;

  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } state_e;

  state_e                state_q, state_d;
  logic [CntW-1:0]       count_q, count_d;
  logic [CntW-1:0]       pos_q, pos_d;
  logic                  drop_q, drop_d;
  logic                  out_valid_q, out_valid_d;
  logic [DataW-1:0]      out_value_q, out_value_d;
  logic [IdxW-1:0]       out_pos_q, out_pos_d;
  logic                  out_last_q, out_last_d;
  logic                  out_empty_q, out_empty_d;
  logic                  out_drop_q, out_drop_d;

  logic                  accept;
  logic                  full;
  logic                  del_ok;
  logic                  fire;
  logic                  rotate;
  oli_pkg::cmd_e         cmd;
  oli_pkg::cell_ctrl_t   ctrl [CAPACITY];
  logic [DataW-1:0]      cell_data [CAPACITY];

  assign accept = in_valid_i && (state_q == ST_IDLE);
  assign cmd    = oli_pkg::cmd_e'(cmd_i);
  assign full   = (count_q == CntW'(CAPACITY));
  assign del_ok = (CmpW'(index_i) < CmpW'(count_q));
  assign fire   = (state_q == ST_DUMP) && (!out_valid_q || !out_stall_i);
  assign rotate = fire && (count_q != '0);

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ctrl[i].op       = oli_pkg::CELL_HOLD;
      ctrl[i].load_val = value_i;
      if (accept) begin
        case (cmd)
          oli_pkg::CMD_FRONT: begin
            if (!full) begin
              ctrl[i].op = (i == 0) ? oli_pkg::CELL_LOAD : oli_pkg::CELL_FROM_LEFT;
            end
          end
          oli_pkg::CMD_BACK: begin
            if (!full && (CntW'(i) == count_q)) begin
              ctrl[i].op = oli_pkg::CELL_LOAD;
            end
          end
          oli_pkg::CMD_DELETE: begin
            if (del_ok && (CmpW'(i) >= CmpW'(index_i))) begin
              ctrl[i].op = oli_pkg::CELL_FROM_RIGHT;
            end
          end
          default: ctrl[i].op = oli_pkg::CELL_HOLD;
        endcase
      end else if (rotate) begin
        if (CntW'(i + 1) < count_q) begin
          ctrl[i].op = oli_pkg::CELL_FROM_RIGHT;
        end else if (CntW'(i + 1) == count_q) begin
          ctrl[i].op = oli_pkg::CELL_FROM_HEAD;
        end
      end
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DataW-1:0] left_w;
    logic [DataW-1:0] right_w;

    if (g == 0) begin : g_first
      assign left_w = value_i;
    end else begin : g_mid_l
      assign left_w = cell_data[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_w = cell_data[0];
    end else begin : g_mid_r
      assign right_w = cell_data[g+1];
    end

    oli_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl[g]),
      .left_i  (left_w),
      .right_i (right_w),
      .head_i  (cell_data[0]),
      .data_o  (cell_data[g])
    );
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pos_d       = pos_q;
    drop_d      = drop_q;
    out_valid_d = out_valid_q;
    out_value_d = out_value_q;
    out_pos_d   = out_pos_q;
    out_last_d  = out_last_q;
    out_empty_d = out_empty_q;
    out_drop_d  = out_drop_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          drop_d  = 1'b0;
          pos_d   = '0;
          state_d = ST_DUMP;
          case (cmd) inside
            oli_pkg::CMD_FRONT, oli_pkg::CMD_BACK: begin
              if (full) begin
                drop_d = 1'b1;
              end else begin
                count_d = count_q + CntW'(1);
              end
            end
            oli_pkg::CMD_DELETE: begin
              if (del_ok) begin
                count_d = count_q - CntW'(1);
              end
            end
            default: count_d = count_q;
          endcase
        end
      end
      ST_DUMP: begin
        if (fire) begin
          out_valid_d = 1'b1;
          out_drop_d  = drop_q;
          out_pos_d   = IdxW'(pos_q);
          if (count_q == '0) begin
            out_value_d = '0;
            out_last_d  = 1'b1;
            out_empty_d = 1'b1;
            state_d     = ST_IDLE;
          end else begin
            out_value_d = cell_data[0];
            out_empty_d = 1'b0;
            out_last_d  = (pos_q + CntW'(1) == count_q);
            pos_d       = pos_q + CntW'(1);
            if (pos_q + CntW'(1) == count_q) begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      pos_q       <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_value_q <= '0;
      out_pos_q   <= '0;
      out_last_q  <= 1'b0;
      out_empty_q <= 1'b0;
      out_drop_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pos_q       <= pos_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
      out_value_q <= out_value_d;
      out_pos_q   <= out_pos_d;
      out_last_q  <= out_last_d;
      out_empty_q <= out_empty_d;
      out_drop_q  <= out_drop_d;
    end
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign entry_value_o = out_value_q;
  assign position_o    = out_pos_q;
  assign last_o        = out_last_q;
  assign empty_res_o   = out_empty_q;
  assign dropped_o     = out_drop_q;

endmodule

`default_nettype wire

// ----- rtl/oli_checker.sv -----
// Port-level checker for the ordered list block and its bind statement.
`timescale 1ns / 1ps
`default_nettype none
`include "ordered_list_insert_delete_assert.svh"

module oli_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           in_stall_o,
  input wire logic                           out_valid_o,
  input wire logic                           out_stall_i,
  input wire logic [oli_pkg::IDX_W-1:0]      position_o,
  input wire logic                           last_o,
  input wire logic                           empty_res_o,
  input wire logic                           dropped_o
);

  logic mid_xfer;

  assign mid_xfer = out_valid_o && !out_stall_i && !last_o;

  `OLI_ASSERT(a_empty_single, clk_i, rst_ni,
    !(out_valid_o && empty_res_o) || (last_o && position_o == '0),
    "An empty-list result must be the only and last result at position zero.")
  `OLI_ASSERT(a_no_cmd_mid_dump, clk_i, rst_ni,
    !(out_valid_o && !last_o) || in_stall_o,
    "A new command must not transfer while a dump is still in progress.")
  `OLI_ASSERT_NEXT(a_dump_continues, clk_i, rst_ni, mid_xfer,
    out_valid_o && position_o == $past(position_o) + 1'b1,
    "The next result must follow at the next position without a gap.")
  `OLI_ASSERT_NEXT(a_drop_steady, clk_i, rst_ni, mid_xfer,
    dropped_o == $past(dropped_o) && !empty_res_o,
    "The dropped flag must stay the same across one dump.")

endmodule

bind ordered_list_insert_delete oli_checker u_oli_checker (.*);

`default_nettype wire
